// ===== hw/rtl/bec_pkg.sv =====
// Package for the backslash escape codec: widths, register indexes, reset values
// and the beat and lookup types shared by the codec modules.
// Depends on nothing.
package bec_pkg;

   localparam int TABLE_ENTRIES = 6;
   localparam int BYTE_W        = 8;
   localparam int TABLE_W       = TABLE_ENTRIES * BYTE_W;
   localparam int COUNT_W       = 3;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = TABLE_W;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QCOUNT_W      = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_DIRECTION_MODE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RAW_BYTE_TABLE  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CODE_LETTER_TBL = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENTRIES_IN_USE  = 2'd3;

   localparam logic MODE_ESCAPE   = 1'b0;
   localparam logic MODE_UNESCAPE = 1'b1;

   localparam logic [BYTE_W-1:0]  BACKSLASH           = 8'h5C;
   localparam logic [TABLE_W-1:0] RAW_TABLE_RESET     = 48'h1B5C090D0A00;
   localparam logic [TABLE_W-1:0] CODE_TABLE_RESET    = 48'h655C74726E30;
   localparam logic [COUNT_W-1:0] ENTRIES_RESET       = 3'd6;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
   } beat_type;

   typedef struct packed {
      logic              hit;
      logic [BYTE_W-1:0] value;
   } lookup_type;

endpackage

// ===== hw/rtl/bec_channels.sv =====
// Handshake channel interfaces of the backslash escape codec: request and response.
// Depends on bec_pkg for the byte width.
interface bec_req_if;
   import bec_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;
   logic              in_last;
   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface bec_rsp_if;
   import bec_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              out_last;
   modport source (output valid, output out_byte, output out_last, input ready);
   modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// ===== hw/rtl/bec_lookup.sv =====
// Table search of the backslash escape codec: finds a byte among the active
// entries of one table and returns the entry of the paired table. Uses bec_pkg.
module bec_lookup (
   input  logic [bec_pkg::BYTE_W-1:0]  key,
   input  logic [bec_pkg::TABLE_W-1:0] search_table,
   input  logic [bec_pkg::TABLE_W-1:0] result_table,
   input  logic [bec_pkg::COUNT_W-1:0] active_count,
   output bec_pkg::lookup_type         result
);
   import bec_pkg::*;

   // Walk from the top entry down so that the lowest matching entry wins.
   always_comb begin
      result.hit   = 1'b0;
      result.value = '0;
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         if ((COUNT_W'(i) < active_count) &&
             (search_table[i*BYTE_W +: BYTE_W] == key)) begin
            result.hit   = 1'b1;
            result.value = result_table[i*BYTE_W +: BYTE_W];
         end
      end
   end

endmodule

// ===== hw/rtl/backslash_escape_codec.sv =====
// Top level of the backslash escape codec: configuration registers, input register,
// translation logic and a two-beat result queue. Uses bec_pkg, bec_channels, bec_lookup.
//
// Converts a byte stream, taking one byte per cycle while the output queue has room. In
// escape mode a byte found in the raw table leaves as a backslash followed by its code
// letter; in unescape mode a backslash not marked last is held and the next byte is mapped
// back through the code letter table, or passes unchanged if not found there. A byte is
// registered in the input register on acceptance, and its results are written from there
// into the two-beat output queue once the queue has room. The sustained rate is
// one request beat per cycle while each byte yields one result and the response port
// is ready; an escaped byte yields two result beats and needs both queue slots, and
// a held backslash yields no result at all. Configuration must only be written while idle.
module backslash_escape_codec (
   input  logic                            clock,
   input  logic                            reset,
   bec_req_if.sink                         req_chan,
   bec_rsp_if.source                       rsp_chan,
   input  logic                            csr_we,
   input  logic [bec_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bec_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import bec_pkg::*;

   logic                mode_ff;
   logic [TABLE_W-1:0]  raw_table_ff;
   logic [TABLE_W-1:0]  code_table_ff;
   logic [COUNT_W-1:0]  entries_ff;
   logic [COUNT_W-1:0]  active_count;

   logic                in_valid_ff;
   beat_type            in_beat_ff;
   logic                pending_ff, pending_in;

   beat_type            queue_ff [QUEUE_DEPTH];
   beat_type            queue_in [QUEUE_DEPTH];
   beat_type            shifted  [QUEUE_DEPTH];
   logic [QCOUNT_W-1:0] qcount_ff, qcount_in;
   logic [QCOUNT_W-1:0] base_count;
   logic [QCOUNT_W-1:0] slot_offset;

   beat_type            results  [QUEUE_DEPTH];
   logic [QCOUNT_W-1:0] result_count;
   lookup_type          found;
   logic [TABLE_W-1:0]  search_table;
   logic [TABLE_W-1:0]  result_table;
   logic                pop;
   logic                take;
   logic                accept;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_ESCAPE;
         raw_table_ff  <= RAW_TABLE_RESET;
         code_table_ff <= CODE_TABLE_RESET;
         entries_ff    <= ENTRIES_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DIRECTION_MODE:  mode_ff       <= csr_wdata[0];
            CSR_RAW_BYTE_TABLE:  raw_table_ff  <= csr_wdata[TABLE_W-1:0];
            CSR_CODE_LETTER_TBL: code_table_ff <= csr_wdata[TABLE_W-1:0];
            CSR_ENTRIES_IN_USE:  entries_ff    <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   assign active_count = (entries_ff > COUNT_W'(TABLE_ENTRIES)) ?
                         COUNT_W'(TABLE_ENTRIES) : entries_ff;

   // Escape searches the raw bytes, unescape searches the code letters.
   assign search_table = (mode_ff == MODE_UNESCAPE) ? code_table_ff : raw_table_ff;
   assign result_table = (mode_ff == MODE_UNESCAPE) ? raw_table_ff : code_table_ff;

   bec_lookup u_lookup (
      .key          (in_beat_ff.data),
      .search_table (search_table),
      .result_table (result_table),
      .active_count (active_count),
      .result       (found)
   );

   // Results of the registered byte.
   always_comb begin
      results[0]   = in_beat_ff;
      results[1]   = in_beat_ff;
      result_count = QCOUNT_W'(1);
      pending_in   = 1'b0;
      if (mode_ff == MODE_ESCAPE) begin
         if (found.hit) begin
            results[0].data = BACKSLASH;
            results[0].last = 1'b0;
            results[1].data = found.value;
            result_count    = QCOUNT_W'(2);
         end
      end else if (pending_ff) begin
         if (found.hit) begin
            results[0].data = found.value;
         end
      end else if ((in_beat_ff.data == BACKSLASH) && !in_beat_ff.last) begin
         result_count = '0;
         pending_in   = 1'b1;
      end
   end

   assign pop        = (qcount_ff != '0) && rsp_chan.ready;
   assign base_count = qcount_ff - QCOUNT_W'(pop);
   assign take       = in_valid_ff && (result_count <= (QCOUNT_W'(QUEUE_DEPTH) - base_count));
   assign accept     = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !in_valid_ff || take;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         pending_ff  <= 1'b0;
      end else begin
         if (accept) begin
            in_valid_ff <= 1'b1;
         end else if (take) begin
            in_valid_ff <= 1'b0;
         end
         if (take) begin
            pending_ff <= pending_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_beat_ff.data <= req_chan.in_byte;
         in_beat_ff.last <= req_chan.in_last;
      end
   end

   // Result queue: drop the head on a beat, then append the new results behind.
   assign shifted[0] = pop ? queue_ff[1] : queue_ff[0];
   assign shifted[1] = queue_ff[1];

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         slot_offset = QCOUNT_W'(i) - base_count;
         queue_in[i] = shifted[i];
         if (take && (QCOUNT_W'(i) >= base_count) && (slot_offset < result_count)) begin
            queue_in[i] = results[slot_offset[0]];
         end
      end
      qcount_in = take ? (base_count + result_count) : base_count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qcount_ff <= '0;
      end else begin
         qcount_ff <= qcount_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         queue_ff[i] <= queue_in[i];
      end
   end

   assign rsp_chan.valid    = (qcount_ff != '0);
   assign rsp_chan.out_byte = queue_ff[0].data;
   assign rsp_chan.out_last = queue_ff[0].last;

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the backslash escape codec: directed and random byte strings in
// both directions, checked beat by beat against a built-in predictor of the conversion.
// Depends on bec_pkg, the channel interfaces in bec_channels and the backslash_escape_codec RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import bec_pkg::*;

   localparam int SETTLE_CYCLES  = 8;
   localparam int LONG_HOLD      = 400;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int RANDOM_PHASES  = 16;
   localparam int PHASE_ITEMS    = 48;

   logic clock;
   logic reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   bec_req_if req_chan ();
   bec_rsp_if rsp_chan ();

   backslash_escape_codec u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Register copies kept by the predictor, updated as each write is made.
   logic               mode_cfg     = MODE_ESCAPE;
   logic [TABLE_W-1:0] raw_tbl_cfg  = RAW_TABLE_RESET;
   logic [TABLE_W-1:0] code_tbl_cfg = CODE_TABLE_RESET;
   logic [COUNT_W-1:0] entries_cfg  = ENTRIES_RESET;
   logic               holding_backslash = 1'b0;

   beat_type pending_items[$];
   beat_type expected_beats[$];

   logic req_taken = 1'b0;
   logic sender_idle_on = 1'b1;
   logic receiver_idle_on = 1'b1;
   int   holds_asked = 0;
   int   holds_done = 0;
   int   send_gap = 0;
   int   rsp_stall_left = 0;
   int   error_count = 0;
   int   rsp_count = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Index of the first active entry holding the byte, or -1 when none does.
   function automatic int find_entry(logic [TABLE_W-1:0] tbl, logic [BYTE_W-1:0] value);
      int n;
      n = (int'(entries_cfg) > TABLE_ENTRIES) ? TABLE_ENTRIES : int'(entries_cfg);
      for (int i = 0; i < n; i++)
         if (tbl[8*i +: 8] == value) return i;
      return -1;
   endfunction

   function automatic void translate_beat(beat_type item);
      int k;
      if (mode_cfg == MODE_ESCAPE) begin
         // Escaping drops any backslash still held from an unescape run.
         holding_backslash = 1'b0;
         k = find_entry(raw_tbl_cfg, item.data);
         if (k >= 0) begin
            expected_beats.push_back('{data: BACKSLASH, last: 1'b0});
            expected_beats.push_back('{data: code_tbl_cfg[8*k +: 8], last: item.last});
         end else begin
            expected_beats.push_back(item);
         end
      end else if (holding_backslash) begin
         holding_backslash = 1'b0;
         k = find_entry(code_tbl_cfg, item.data);
         expected_beats.push_back('{data: (k >= 0) ? raw_tbl_cfg[8*k +: 8] : item.data,
                                    last: item.last});
      end else if (item.data == BACKSLASH && !item.last) begin
         holding_backslash = 1'b1;
      end else begin
         expected_beats.push_back(item);
      end
   endfunction

   task automatic report_mismatch(string msg);
      $display("mismatch: %s", msg);
      error_count++;
   endtask

   // Request driver: holds an offered beat until it is taken, then idles or offers the next.
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_taken) begin
         if (send_gap > 0) begin
            req_chan.valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (pending_items.size() > 0) begin
            req_chan.valid   <= 1'b1;
            req_chan.in_byte <= pending_items[0].data;
            req_chan.in_last <= pending_items[0].last;
            void'(pending_items.pop_front());
            send_gap <= sender_idle_on ? pick_gap() : 0;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Response ready: random stalls, plus the occasional long hold-off that backs the block up.
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (rsp_stall_left > 0) begin
         rsp_chan.ready <= 1'b0;
         rsp_stall_left <= rsp_stall_left - 1;
      end else if (holds_done != holds_asked) begin
         rsp_chan.ready <= 1'b0;
         rsp_stall_left <= LONG_HOLD - 1;
         holds_done <= holds_done + 1;
      end else begin
         rsp_chan.ready <= 1'b1;
         if (receiver_idle_on && $urandom_range(0, 3) == 0)
            rsp_stall_left <= pick_gap();
      end
   end

   always @(posedge clock) begin : monitor
      beat_type offered;
      beat_type want;
      req_taken <= req_chan.valid && req_chan.ready;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            offered.data = req_chan.in_byte;
            offered.last = req_chan.in_last;
            translate_beat(offered);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_beats.size() == 0) begin
               report_mismatch($sformatf("result beat %0d (0x%02h) with nothing expected",
                                         rsp_count, rsp_chan.out_byte));
            end else begin
               want = expected_beats.pop_front();
               if (rsp_chan.out_byte !== want.data)
                  report_mismatch($sformatf("result beat %0d: out_byte 0x%02h, expected 0x%02h",
                                            rsp_count, rsp_chan.out_byte, want.data));
               if (rsp_chan.out_last !== want.last)
                  report_mismatch($sformatf("result beat %0d: out_last %0b, expected %0b",
                                            rsp_count, rsp_chan.out_last, want.last));
            end
            rsp_count++;
         end
      end
   end

   // Ends the run when neither channel has moved a beat for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("backslash_escape_codec regression: fail");
      $finish;
   end

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_DIRECTION_MODE:  mode_cfg     = value[0];
         CSR_RAW_BYTE_TABLE:  raw_tbl_cfg  = value[TABLE_W-1:0];
         CSR_CODE_LETTER_TBL: code_tbl_cfg = value[TABLE_W-1:0];
         CSR_ENTRIES_IN_USE:  entries_cfg  = value[COUNT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(logic mode, logic [TABLE_W-1:0] raw, logic [TABLE_W-1:0] code,
                                 logic [COUNT_W-1:0] entries);
      write_csr(CSR_DIRECTION_MODE, CSR_DATA_W'(mode));
      write_csr(CSR_RAW_BYTE_TABLE, raw);
      write_csr(CSR_CODE_LETTER_TBL, code);
      write_csr(CSR_ENTRIES_IN_USE, CSR_DATA_W'(entries));
      @(posedge clock);
   endtask

   // A held backslash gives no result, so the wait ends when the queues run empty and then settles.
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_chan.valid || expected_beats.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic queue_beat(logic [BYTE_W-1:0] value, logic last);
      pending_items.push_back('{data: value, last: last});
   endtask

   task automatic queue_text(string s, logic last_at_end);
      for (int i = 0; i < s.len(); i++)
         queue_beat(s[i], last_at_end && (i == s.len() - 1));
   endtask

   function automatic logic [BYTE_W-1:0] pick_entry(logic [TABLE_W-1:0] tbl);
      int i;
      i = $urandom_range(0, TABLE_ENTRIES - 1);
      return tbl[8*i +: 8];
   endfunction

   // Tables rich in backslashes and repeated entries, so that first-match ordering is exercised.
   function automatic logic [TABLE_W-1:0] random_table();
      logic [TABLE_W-1:0] tbl;
      int r;
      tbl = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         r = $urandom_range(0, 7);
         if (r < 2)
            tbl[8*i +: 8] = BACKSLASH;
         else if (r < 4 && i > 0)
            tbl[8*i +: 8] = tbl[8*(i-1) +: 8];
         else
            tbl[8*i +: 8] = 8'($urandom_range(0, 255));
      end
      return tbl;
   endfunction

   // Mostly well-formed text for the current direction, with random bytes mixed in.
   task automatic queue_random_text(int count);
      int r;
      logic last;
      repeat (count) begin
         r = $urandom_range(0, 99);
         last = ($urandom_range(0, 7) == 0);
         if (mode_cfg == MODE_UNESCAPE && r < 45) begin
            queue_beat(BACKSLASH, 1'b0);
            queue_beat(pick_entry(code_tbl_cfg), last);
         end else if (r < 60) begin
            queue_beat(pick_entry(raw_tbl_cfg), last);
         end else if (r < 72) begin
            queue_beat(BACKSLASH, last);
         end else begin
            queue_beat(8'($urandom_range(0, 255)), last);
         end
      end
   endtask

   initial begin : stimulus
      logic               mode;
      logic [TABLE_W-1:0] raw;
      logic [TABLE_W-1:0] code;
      logic [COUNT_W-1:0] entries;

      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      req_chan.valid    = 1'b0;
      req_chan.in_byte  = '0;
      req_chan.in_last  = 1'b0;
      rsp_chan.ready    = 1'b0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Escape with the reset tables: every raw entry, bytes that pass, both field extremes.
      for (int i = 0; i < TABLE_ENTRIES; i++)
         queue_beat(RAW_TABLE_RESET[8*i +: 8], 1'b0);
      queue_beat(8'hFF, 1'b0);
      queue_beat(8'h41, 1'b1);
      wait_idle();

      // Unescape: known codes, a backslash pair, an unknown code, a lone trailing backslash,
      // a held backslash resolved on the final byte, and one left held across the mode change.
      write_csr(CSR_DIRECTION_MODE, CSR_DATA_W'(MODE_UNESCAPE));
      @(posedge clock);
      queue_text("\\0\\n\\\\\\e\\q", 1'b1);
      queue_text("\\", 1'b1);
      queue_text("x\\t", 1'b1);
      queue_text("\\", 1'b0);
      wait_idle();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: begin
               mode = MODE_ESCAPE;   raw = RAW_TABLE_RESET; code = CODE_TABLE_RESET;
               entries = 3'd7;
            end
            1: begin
               mode = MODE_ESCAPE;   raw = '0; code = '1; entries = 3'd1;
            end
            2: begin
               mode = MODE_UNESCAPE; raw = '1; code = '0; entries = 3'd7;
            end
            3: begin
               mode = MODE_UNESCAPE; raw = RAW_TABLE_RESET; code = CODE_TABLE_RESET;
               entries = 3'd0;
            end
            4: begin
               mode = MODE_ESCAPE;   raw = RAW_TABLE_RESET; code = CODE_TABLE_RESET;
               entries = ENTRIES_RESET;
            end
            default: begin
               mode    = 1'($urandom_range(0, 1));
               raw     = random_table();
               code    = random_table();
               entries = 3'($urandom_range(0, 7));
            end
         endcase
         apply_settings(mode, raw, code, entries);
         sender_idle_on   = ($urandom_range(0, 3) != 0);
         receiver_idle_on = ($urandom_range(0, 3) != 0);
         if (p == 4) begin
            // The sender keeps offering while the receiver holds off, so the block backs up.
            sender_idle_on = 1'b0;
            holds_asked++;
         end
         queue_random_text(PHASE_ITEMS);
         wait_idle();
      end

      if (error_count == 0)
         $display("backslash_escape_codec regression: pass");
      else
         $display("backslash_escape_codec regression: fail");
      $finish;
   end

endmodule
